FILE: hdl/mrb_pkg.sv
// ---------------------------------------------------------------------------
// mrb_pkg
// Shared constants and types for the modal resonator bank.
// ---------------------------------------------------------------------------
package mrb_pkg;

  localparam int MAX_MODES = 16384;
  localparam int MODE_W    = $clog2(MAX_MODES);
  localparam int CNT_W     = MODE_W + 1;
  localparam int DISP_W    = 48;
  localparam int COEF_W    = 32;
  localparam int SAMPLE_W  = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ACTIVE_W   = 15;
  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MODES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 15'd12952;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 16'd170;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd20000;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef logic [MODE_W-1:0] mode_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] w;
    logic signed [COEF_W-1:0] p;
  } coef_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] x;
    logic signed [DISP_W-1:0] xp;
  } disp_t;

endpackage

FILE: hdl/mrb_if.sv
// ---------------------------------------------------------------------------
// mrb_if
// Valid/ready channels of the modal resonator bank: request and sample.
// ---------------------------------------------------------------------------
interface mrb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        armed;
  logic [13:0] mode_index;
  logic signed [31:0] feedback_a;
  logic signed [31:0] feedback_b;
  logic signed [31:0] drive_weight;
  logic signed [31:0] pickup_weight;

  modport source (output valid, req_type, armed, mode_index, feedback_a, feedback_b,
                  drive_weight, pickup_weight, input ready);
  modport sink   (input valid, req_type, armed, mode_index, feedback_a, feedback_b,
                  drive_weight, pickup_weight, output ready);
endinterface

interface mrb_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] audio_sample;

  modport source (output valid, audio_sample, input ready);
  modport sink   (input valid, audio_sample, output ready);
endinterface

FILE: hdl/modal_resonator_bank_top.sv
// ---------------------------------------------------------------------------
// modal_resonator_bank_top
// Bank of damped two-pole modal resonators with one summed audio output.
// ---------------------------------------------------------------------------
// After reset the block zeroes the displacement memory and takes no beat
// meanwhile. An armed tick walks the active modes through a six-stage
// pipeline, one mode a cycle, out of one coefficient memory and one
// displacement memory (read, update, write back), and the block takes no new
// beat until its sample is registered. Load beats write the coefficient memory;
// unarmed and priming ticks produce no sample.
module modal_resonator_bank_top (
  input  logic                         clk,
  input  logic                         rst_n,
  mrb_in_if.sink                       in_ch,
  mrb_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [mrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mrb_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RUN, S_FIN1, S_FIN2} state_t;

  state_t state_r;

  // Memories
  coef_t cf_mem [MAX_MODES];
  disp_t st_mem [MAX_MODES];

  // Config
  logic [ACTIVE_W-1:0] active_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [GAIN_W-1:0]   gain_r;

  logic            primed_r;
  mode_idx_t       clr_cnt_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_eff;
  logic            issue;
  logic [6:1]      vld_r;
  logic            in_acc;

  // Pipeline payload
  mode_idx_t a1_r, a2_r, a3_r, a4_r;
  coef_t     c1_r;
  disp_t     d1_r;
  logic signed [55:0] at_r, bt_r;
  logic signed [56:0] au_r, bu_r;
  logic signed [48:0] wd_r;
  logic signed [DISP_W-1:0] x2_r, x3_r, x4_r, nx4_r;
  logic signed [COEF_W-1:0] p2_r, p3_r, p4_r;
  logic signed [50:0] ta3_r, tb3_r;
  logic signed [33:0] td3_r;
  logic signed [55:0] ph_r;
  logic signed [56:0] pl_r;
  logic signed [60:0] term_r;
  logic signed [63:0] acc_r;
  logic signed [48:0] gh_r;
  logic signed [49:0] gl_r;
  logic               out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Combinational datapath
  logic signed [80:0] pa_sum, pb_sum, pk_sum, g_sum;
  logic signed [49:0] wd_sum;
  logic signed [52:0] nx_sum;
  logic signed [DISP_W-1:0] nx_sat;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_nxt;
  logic signed [55:0] smp_wide;
  logic signed [SAMPLE_W-1:0] smp_sat;
  logic               out_free;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.audio_sample = out_sample_r;
  assign out_free      = !out_valid_r || out_ch.ready;

  assign n_eff = (active_r > ACTIVE_W'(MAX_MODES)) ? CNT_W'(MAX_MODES) : CNT_W'(active_r);
  assign issue = (state_r == S_RUN) && (cnt_r < n_eff);

  // Rounded partial-product recombination
  assign pa_sum = {at_r[55], at_r, 24'd0} + {{24{au_r[56]}}, au_r} + (81'sd1 <<< 29);
  assign pb_sum = {bt_r[55], bt_r, 24'd0} + {{24{bu_r[56]}}, bu_r} + (81'sd1 <<< 29);
  assign wd_sum = {wd_r[48], wd_r} + 50'sd32768;
  assign nx_sum = {{2{ta3_r[50]}}, ta3_r} + {{2{tb3_r[50]}}, tb3_r}
                + {{19{td3_r[33]}}, td3_r};
  assign pk_sum = {ph_r[55], ph_r, 24'd0} + {{24{pl_r[56]}}, pl_r} + (81'sd1 <<< 19);
  assign g_sum  = {gh_r, 32'd0} + {{31{gl_r[49]}}, gl_r} + (81'sd1 <<< 24);

  // Clamp next displacement to 48 bits
  always_comb begin
    if (nx_sum > 53'sh7FFF_FFFF_FFFF) begin
      nx_sat = {1'b0, {(DISP_W-1){1'b1}}};
    end else if (nx_sum < -53'sh8000_0000_0000) begin
      nx_sat = {1'b1, {(DISP_W-1){1'b0}}};
    end else begin
      nx_sat = nx_sum[DISP_W-1:0];
    end
  end

  // Saturating accumulate
  always_comb begin
    acc_sum = {acc_r[63], acc_r} + {{4{term_r[60]}}, term_r};
    if (acc_sum[64] != acc_sum[63]) begin
      acc_nxt = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_nxt = acc_sum[63:0];
    end
  end

  // Output scaling and clamp
  always_comb begin
    smp_wide = g_sum[80:25];
    if (smp_wide > 56'sd8388607) begin
      smp_sat = 24'sh7FFFFF;
    end else if (smp_wide < -56'sd8388608) begin
      smp_sat = -24'sh800000;
    end else begin
      smp_sat = smp_wide[SAMPLE_W-1:0];
    end
  end

  // Coefficient memory: written on load beats, read while running
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == REQ_LOAD) begin
      cf_mem[in_ch.mode_index] <= '{a: in_ch.feedback_a, b: in_ch.feedback_b,
                                    w: in_ch.drive_weight, p: in_ch.pickup_weight};
    end
    if (issue) begin
      c1_r <= cf_mem[cnt_r[MODE_W-1:0]];
    end
  end

  // Displacement memory: cleared after reset, written back from stage 4
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      st_mem[clr_cnt_r] <= '0;
    end else if (vld_r[4]) begin
      st_mem[a4_r] <= '{x: nx4_r, xp: x4_r};
    end
    if (issue) begin
      d1_r <= st_mem[cnt_r[MODE_W-1:0]];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (issue) a1_r <= cnt_r[MODE_W-1:0];
    // stage 2: partial products
    a2_r <= a1_r;
    at_r <= $signed(d1_r.x[47:24]) * c1_r.a;
    au_r <= $signed({1'b0, d1_r.x[23:0]}) * c1_r.a;
    bt_r <= $signed(d1_r.xp[47:24]) * c1_r.b;
    bu_r <= $signed({1'b0, d1_r.xp[23:0]}) * c1_r.b;
    wd_r <= c1_r.w * $signed({1'b0, level_r});
    x2_r <= d1_r.x;
    p2_r <= c1_r.p;
    // stage 3: rounded terms
    a3_r  <= a2_r;
    ta3_r <= pa_sum[80:30];
    tb3_r <= pb_sum[80:30];
    td3_r <= wd_sum[49:16];
    x3_r  <= x2_r;
    p3_r  <= p2_r;
    // stage 4: next displacement
    a4_r  <= a3_r;
    nx4_r <= nx_sat;
    x4_r  <= x3_r;
    p4_r  <= p3_r;
    // stage 5: pickup partial products
    ph_r <= $signed(nx4_r[47:24]) * p4_r;
    pl_r <= $signed({1'b0, nx4_r[23:0]}) * p4_r;
    // stage 6: rounded pickup term
    term_r <= pk_sum[80:20];
    // finish: gain partial products
    gh_r <= $signed(acc_r[63:32]) * $signed({1'b0, gain_r});
    gl_r <= $signed({1'b0, acc_r[31:0]}) * $signed({1'b0, gain_r});
  end

  // Control, config and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      primed_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RST;
      level_r     <= LEVEL_RST;
      gain_r      <= GAIN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_MODES: active_r <= cfg_wdata[ACTIVE_W-1:0];
          REG_DRIVE_LEVEL:  level_r  <= cfg_wdata[LEVEL_W-1:0];
          REG_OUTPUT_GAIN:  gain_r   <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      vld_r <= {vld_r[5:1], issue};
      if (issue) cnt_r <= cnt_r + 1'b1;
      if (vld_r[6]) acc_r <= acc_nxt;

      // Output register: load a finished sample, else drop the one taken
      if (state_r == S_FIN2 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == {MODE_W{1'b1}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc && in_ch.req_type == REQ_TICK && in_ch.armed) begin
            if (!primed_r) begin
              primed_r <= 1'b1;
            end else begin
              cnt_r   <= '0;
              acc_r   <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (!issue && vld_r == '0) state_r <= S_FIN1;
        end
        S_FIN1: begin
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          if (out_free) begin
            out_sample_r <= smp_sat;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/mrb_checker.sv
// ---------------------------------------------------------------------------
// mrb_checker
// Watches the request, sample and register ports of the resonator bank. It
// keeps its own copy of the mode state, predicts each audio sample and
// compares every sample beat against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mrb_in_if                              in_ch,
  mrb_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [mrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             err_count,
  output int                             pending,
  output int                             samples_seen
);
  import mrb_pkg::*;

  localparam longint DISP_MAX = (64'sd1 <<< 47) - 1;
  localparam longint DISP_MIN = -(64'sd1 <<< 47);

  // Model state
  logic signed [DISP_W-1:0] pos_mem  [MAX_MODES];
  logic signed [DISP_W-1:0] prev_mem [MAX_MODES];
  coef_t                    coef_mem [MAX_MODES];
  logic                     is_primed;
  logic [ACTIVE_W-1:0]      mode_count;
  logic [LEVEL_W-1:0]       drive_lvl;
  logic [GAIN_W-1:0]        gain;

  logic signed [SAMPLE_W-1:0] sample_q[$];

  // round(p*q / 2^s), ties toward +inf
  function automatic longint round_mul(longint p, int q, int s);
    logic signed [95:0] pw, qw, prod;
    pw = p;
    qw = q;
    prod = (pw * qw + (96'sd1 <<< (s - 1))) >>> s;
    return prod[63:0];
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return sum[63:0];
  endfunction

  // Advance all active modes once and return the scaled sample
  function automatic logic signed [SAMPLE_W-1:0] advance_bank();
    int                 n;
    longint             x, xp, ta, tb, td, nx, acc;
    logic signed [63:0] wd, lv;
    logic signed [95:0] aw, gw, scaled;
    n = (mode_count > MAX_MODES) ? MAX_MODES : int'(mode_count);
    acc = 0;
    lv = drive_lvl;
    for (int m = 0; m < n; m++) begin
      x  = pos_mem[m];
      xp = prev_mem[m];
      ta = round_mul(x, coef_mem[m].a, 30);
      tb = round_mul(xp, coef_mem[m].b, 30);
      wd = coef_mem[m].w;
      td = (wd * lv + (64'sd1 <<< 15)) >>> 16;
      nx = ta + tb + td;
      if (nx > DISP_MAX) nx = DISP_MAX;
      if (nx < DISP_MIN) nx = DISP_MIN;
      prev_mem[m] = x;
      pos_mem[m]  = nx;
      acc = sat_add(acc, round_mul(nx, coef_mem[m].p, 20));
    end
    aw = acc;
    gw = gain;
    scaled = (aw * gw + (96'sd1 <<< 24)) >>> 25;
    if (scaled > 96'sd8388607) scaled = 96'sd8388607;
    if (scaled < -96'sd8388608) scaled = -96'sd8388608;
    return scaled[SAMPLE_W-1:0];
  endfunction

  assign pending = sample_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pos_mem[i]) begin
        pos_mem[i]  = '0;
        prev_mem[i] = '0;
      end
      is_primed    <= 1'b0;
      mode_count   <= ACTIVE_RST;
      drive_lvl    <= LEVEL_RST;
      gain         <= GAIN_RST;
      err_count    <= 0;
      samples_seen <= 0;
      sample_q.delete();
    end else begin
      // Sample beats against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        samples_seen <= samples_seen + 1;
        if (sample_q.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected sample %0d", $realtime, out_ch.audio_sample);
          err_count <= err_count + 1;
        end else if (sample_q[0] !== out_ch.audio_sample) begin
          if (err_count < 10)
            $display("%0t: audio_sample expected %0d got %0d", $realtime,
                     sample_q[0], out_ch.audio_sample);
          err_count <= err_count + 1;
          void'(sample_q.pop_front());
        end else begin
          void'(sample_q.pop_front());
        end
      end

      // Request beats
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == REQ_LOAD) begin
          coef_mem[in_ch.mode_index] = '{a: in_ch.feedback_a, b: in_ch.feedback_b,
                                         w: in_ch.drive_weight, p: in_ch.pickup_weight};
        end else if (in_ch.armed) begin
          if (!is_primed) is_primed <= 1'b1;
          else sample_q.push_back(advance_bank());
        end
      end

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_MODES: mode_count <= cfg_wdata[ACTIVE_W-1:0];
          REG_DRIVE_LEVEL:  drive_lvl  <= cfg_wdata[LEVEL_W-1:0];
          REG_OUTPUT_GAIN:  gain       <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the modal resonator bank: directed coefficient extremes and
// register corners, then random load/tick traffic under three idling
// patterns. The checker judges every sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mrb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    err_count, pending, samples_seen;
  int                    src_idle, snk_idle;
  int                    active_now;
  int                    beats_sent;

  mrb_in_if  in_ch ();
  mrb_out_if out_ch ();

  modal_resonator_bank_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  mrb_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .err_count   (err_count),
    .pending     (pending),
    .samples_seen(samples_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sample-side stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // One request beat, with random sender gaps before it
  task automatic send_beat(logic kind, logic arm, logic [13:0] idx, coef_t c);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= kind;
    in_ch.armed         <= arm;
    in_ch.mode_index    <= idx;
    in_ch.feedback_a    <= c.a;
    in_ch.feedback_b    <= c.b;
    in_ch.drive_weight  <= c.w;
    in_ch.pickup_weight <= c.p;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic tick(logic arm);
    send_beat(REQ_TICK, arm, 14'($urandom), coef_t'({$urandom, $urandom, $urandom, $urandom}));
  endtask

  // Decaying resonator coefficients, random drive and pickup
  function automatic coef_t ringing_coef();
    real   r, th;
    coef_t c;
    r   = 0.9 + 0.0999 * $urandom_range(1000) / 1000.0;
    th  = 3.14159 * $urandom_range(1000) / 1000.0;
    c.a = int'(2.0 * r * $cos(th) * 1073741824.0 * 0.999);
    c.b = -int'(r * r * 1073741824.0);
    c.w = $urandom;
    c.p = $urandom;
    return c;
  endfunction

  function automatic coef_t raw_coef();
    return coef_t'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // Wait until every sample is in and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (active_now + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_ACTIVE_MODES) active_now = (val > MAX_MODES) ? MAX_MODES : val;
  endtask

  task automatic random_traffic(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)      tick(1'b1);
      else if (pick < 65) tick(1'b0);
      else if (pick < 82) send_beat(REQ_LOAD, 1'($urandom), 14'($urandom_range(15)),
                                    ringing_coef());
      else if (pick < 92) send_beat(REQ_LOAD, 1'($urandom), 14'($urandom_range(15)),
                                    raw_coef());
      else                send_beat(REQ_LOAD, 1'($urandom), 14'($urandom), raw_coef());
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_LOAD;
    in_ch.armed         <= 1'b0;
    in_ch.mode_index    <= '0;
    in_ch.feedback_a    <= '0;
    in_ch.feedback_b    <= '0;
    in_ch.drive_weight  <= '0;
    in_ch.pickup_weight <= '0;
    src_idle   = 7;
    snk_idle   = 75;
    active_now = ACTIVE_RST;
    beats_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coefficient extremes, priming, register corners
    write_reg(REG_ACTIVE_MODES, 2);
    write_reg(REG_DRIVE_LEVEL, 65535);
    write_reg(REG_OUTPUT_GAIN, 65535);
    send_beat(REQ_LOAD, 1'b1, 14'd0, '{a: 32'h7fffffff, b: 32'h80000000,
                                       w: 32'h7fffffff, p: 32'h7fffffff});
    send_beat(REQ_LOAD, 1'b0, 14'd1, '{a: 32'h80000000, b: 32'h7fffffff,
                                       w: 32'h80000000, p: 32'h80000000});
    for (int m = 2; m < 16; m++) send_beat(REQ_LOAD, 1'b0, 14'(m), ringing_coef());
    send_beat(REQ_LOAD, 1'b1, 14'h3fff, raw_coef());
    tick(1'b0);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    settle();
    write_reg(REG_ACTIVE_MODES, 0);
    tick(1'b1);
    settle();
    write_reg(REG_ACTIVE_MODES, 16);
    write_reg(REG_DRIVE_LEVEL, 0);
    write_reg(REG_OUTPUT_GAIN, 0);
    tick(1'b1);
    settle();

    // Random traffic under three idling patterns
    write_reg(REG_DRIVE_LEVEL, 170);
    write_reg(REG_OUTPUT_GAIN, 20000);
    random_traffic(26);
    settle();
    src_idle = 75;
    snk_idle = 7;
    write_reg(REG_ACTIVE_MODES, 1);
    write_reg(REG_DRIVE_LEVEL, $urandom_range(65535));
    write_reg(REG_OUTPUT_GAIN, $urandom_range(65535));
    random_traffic(26);
    settle();
    src_idle = 0;
    snk_idle = 0;
    write_reg(REG_ACTIVE_MODES, $urandom_range(16, 1));
    write_reg(REG_OUTPUT_GAIN, 1);
    write_reg(REG_DRIVE_LEVEL, 1);
    random_traffic(26);
    settle();

    $display("Sent %0d request beats; %0d samples compared.", beats_sent, samples_seen);
    $display("Covered coefficient extremes, priming, zero and small mode counts.");
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(12ns * 1500000);
    $display("tb_top failed");
    $finish;
  end

endmodule
